[hdl/cau_pkg.sv]
// ----------------------------------------------------------------------------
// cau_pkg: shared types for the complex arithmetic unit
// Item layouts for the request and response channels, op codes and status codes.
// ----------------------------------------------------------------------------
package cau_pkg;

   // Field width of every operand and result part (signed fixed point)
   localparam int DATA_W = 16;
   // Default number of fraction bits (Q8.8)
   localparam int FRAC_BITS_DEF = 8;

   typedef enum logic [1:0] {
      OP_ADD = 2'd0,
      OP_SUB = 2'd1,
      OP_MUL = 2'd2,
      OP_DIV = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_OK   = 2'd0,
      ST_SAT  = 2'd1,
      ST_DIV0 = 2'd2
   } status_type;

   typedef struct packed {
      op_type                    op;
      logic signed [DATA_W-1:0]  a_real;
      logic signed [DATA_W-1:0]  a_imag;
      logic signed [DATA_W-1:0]  b_real;
      logic signed [DATA_W-1:0]  b_imag;
   } req_type;

   typedef struct packed {
      logic signed [DATA_W-1:0]  res_real;
      logic signed [DATA_W-1:0]  res_imag;
      status_type                status;
   } rsp_type;

endpackage

[hdl/complex_arithmetic_unit.sv]
// ----------------------------------------------------------------------------
// complex_arithmetic_unit: pipelined complex add / subtract / multiply / divide
// Usage:
//   Request channel (req_valid, req_stall, req_data) carries an op code and two
//   complex operands a and b in signed fixed point with FRAC_BITS fraction bits.
//   Response channel (rsp_valid, rsp_stall, rsp_data) returns one item per
//   request: real and imaginary parts, saturated to the field width, and a
//   status code (ok, saturated, divide by zero).
//   Every op passes the same registers in order: one stage of multipliers,
//   one combining stage, one sign/setup stage, a restoring divider of one
//   quotient bit per stage (DATA_W stages) and the saturating output
//   register. Ops other than divide ride through the divider stages
//   unchanged, so items leave in the order they came in.
//   Throughput is one item per cycle while the receiver does not stall; the
//   depth of the divider chain sets the latency, not the rate.
//   When the receiver stalls while a response is held, the whole pipeline
//   freezes and req_stall is raised in the same cycle; nothing is lost.
//   Reset (synchronous, active high) clears all stage valid bits; no item is
//   in flight afterwards. Payload registers are not reset.
// ----------------------------------------------------------------------------
module complex_arithmetic_unit #(
   parameter int FRAC_BITS = cau_pkg::FRAC_BITS_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  cau_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output cau_pkg::rsp_type rsp_data
);

   localparam int W  = cau_pkg::DATA_W;
   localparam int PW = 2 * W;           // product width
   localparam int SW = 2 * W + 1;       // combined sum width (signed)
   localparam int MW = SW;              // magnitude width
   localparam int DW = 2 * W;           // squared magnitude of b
   localparam int NW = MW + FRAC_BITS;  // shifted numerator
   localparam int CW = NW + W;          // overflow compare width
   localparam logic [MW-1:0] RND  = MW'((64'd1 << FRAC_BITS) - 64'd1);
   localparam logic [MW-1:0] HALF = MW'(1) << (W - 1);
   localparam logic [MW-1:0] MAXP = HALF - MW'(1);
   localparam logic [W-1:0]  MAXV = {1'b0, {(W-1){1'b1}}};
   localparam logic [W-1:0]  MINV = {1'b1, {(W-1){1'b0}}};

   logic en;

   // Whole pipeline advances unless a held response is stalled
   assign en        = !(rsp_valid && rsp_stall);
   assign req_stall = !en;

   // ------------------------------------------------------------------
   // Stage A: products and part-wise sums
   // ------------------------------------------------------------------
   logic                 a_v_ff;
   cau_pkg::op_type      a_op_ff;
   logic signed [PW-1:0] a_prr_ff, a_pii_ff, a_pri_ff, a_pir_ff, a_pbr_ff, a_pbi_ff;
   logic signed [W:0]    a_sr_ff, a_si_ff;
   logic signed [W:0]    a_sr_in, a_si_in;
   logic signed [W:0]    ext_ar, ext_ai, ext_br, ext_bi;

   assign ext_ar = {req_data.a_real[W-1], req_data.a_real};
   assign ext_ai = {req_data.a_imag[W-1], req_data.a_imag};
   assign ext_br = {req_data.b_real[W-1], req_data.b_real};
   assign ext_bi = {req_data.b_imag[W-1], req_data.b_imag};

   always_comb begin
      if (req_data.op == cau_pkg::OP_SUB) begin
         a_sr_in = ext_ar - ext_br;
         a_si_in = ext_ai - ext_bi;
      end else begin
         a_sr_in = ext_ar + ext_br;
         a_si_in = ext_ai + ext_bi;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_v_ff <= 1'b0;
      end else if (en) begin
         a_v_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         a_op_ff  <= req_data.op;
         a_prr_ff <= req_data.a_real * req_data.b_real;
         a_pii_ff <= req_data.a_imag * req_data.b_imag;
         a_pri_ff <= req_data.a_real * req_data.b_imag;
         a_pir_ff <= req_data.a_imag * req_data.b_real;
         a_pbr_ff <= req_data.b_real * req_data.b_real;
         a_pbi_ff <= req_data.b_imag * req_data.b_imag;
         a_sr_ff  <= a_sr_in;
         a_si_ff  <= a_si_in;
      end
   end

   // ------------------------------------------------------------------
   // Stage B: combine products, squared magnitude of b
   // ------------------------------------------------------------------
   logic                 b_v_ff;
   cau_pkg::op_type      b_op_ff;
   logic signed [SW-1:0] b_ur_ff, b_ui_ff, b_ur_in, b_ui_in;
   logic [DW-1:0]        b_d_ff, b_d_in;
   logic signed [SW-1:0] x_rr, x_ii, x_ri, x_ir;

   assign x_rr = {a_prr_ff[PW-1], a_prr_ff};
   assign x_ii = {a_pii_ff[PW-1], a_pii_ff};
   assign x_ri = {a_pri_ff[PW-1], a_pri_ff};
   assign x_ir = {a_pir_ff[PW-1], a_pir_ff};
   // both squares are non-negative and their sum fits DW bits
   assign b_d_in = a_pbr_ff[DW-1:0] + a_pbi_ff[DW-1:0];

   always_comb begin
      case (a_op_ff)
         cau_pkg::OP_MUL: begin
            b_ur_in = x_rr - x_ii;
            b_ui_in = x_ri + x_ir;
         end
         cau_pkg::OP_DIV: begin
            b_ur_in = x_rr + x_ii;
            b_ui_in = x_ir - x_ri;
         end
         default: begin
            b_ur_in = SW'(a_sr_ff);
            b_ui_in = SW'(a_si_ff);
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_v_ff <= 1'b0;
      end else if (en) begin
         b_v_ff <= a_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         b_op_ff <= a_op_ff;
         b_ur_ff <= b_ur_in;
         b_ui_ff <= b_ui_in;
         b_d_ff  <= b_d_in;
      end
   end

   // ------------------------------------------------------------------
   // Divider stages 0..W; stage 0 is sign / rounding / divider setup
   // ------------------------------------------------------------------
   logic                   s_v_ff   [0:W];
   logic                   s_div_ff [0:W];
   logic                   s_dz_ff  [0:W];
   logic [1:0]             s_neg_ff [0:W];
   logic [1:0]             s_ovf_ff [0:W];
   logic [1:0][MW-1:0]     s_val_ff [0:W];
   logic [1:0][DW-1:0]     s_rem_ff [0:W];
   logic [1:0][W-1:0]      s_num_ff [0:W];
   logic [DW-1:0]          s_d_ff   [0:W];

   logic [1:0]             c_neg_in, c_ovf_in;
   logic [1:0][MW-1:0]     c_val_in;
   logic [1:0][DW-1:0]     c_rem_in;
   logic [1:0][W-1:0]      c_num_in;

   always_comb begin
      logic signed [SW-1:0] x;
      logic [MW-1:0]        mag;
      logic [MW:0]          rnd;
      logic [NW-1:0]        n_c;
      logic [NW-1:0]        n_sh;
      for (int p = 0; p < 2; p++) begin
         x   = (p == 0) ? b_ur_ff : b_ui_ff;
         c_neg_in[p] = x[SW-1];
         mag = x[SW-1] ? MW'(-x) : MW'(x);
         // floor shift of a negative value rounds the magnitude up
         rnd = x[SW-1] ? ({1'b0, mag} + {1'b0, RND}) : {1'b0, mag};
         n_c  = {mag, {FRAC_BITS{1'b0}}};
         n_sh = n_c >> W;
         c_num_in[p] = n_c[W-1:0];
         c_rem_in[p] = n_sh[DW-1:0];
         c_ovf_in[p] = 1'b0;
         case (b_op_ff)
            cau_pkg::OP_MUL: begin
               c_val_in[p] = MW'(rnd >> FRAC_BITS);
            end
            cau_pkg::OP_DIV: begin
               // quotient of 2^W or more always saturates
               c_val_in[p] = '0;
               c_ovf_in[p] = ({{W{1'b0}}, n_c} >=
                              {{(CW-DW-W){1'b0}}, b_d_ff, {W{1'b0}}});
            end
            default: begin
               c_val_in[p] = mag;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s_v_ff[0] <= 1'b0;
      end else if (en) begin
         s_v_ff[0] <= b_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s_div_ff[0] <= (b_op_ff == cau_pkg::OP_DIV);
         s_dz_ff[0]  <= (b_op_ff == cau_pkg::OP_DIV) && (b_d_ff == '0);
         s_neg_ff[0] <= c_neg_in;
         s_ovf_ff[0] <= c_ovf_in;
         s_val_ff[0] <= c_val_in;
         s_rem_ff[0] <= c_rem_in;
         s_num_ff[0] <= c_num_in;
         s_d_ff[0]   <= b_d_ff;
      end
   end

   // One restoring quotient bit per stage, both parts side by side
   for (genvar k = 1; k <= W; k++) begin : g_div
      logic [1:0][MW-1:0] val_in;
      logic [1:0][DW-1:0] rem_in;
      logic [1:0][W-1:0]  num_in;

      always_comb begin
         logic [DW:0] t;
         logic        ge;
         for (int p = 0; p < 2; p++) begin
            t  = {s_rem_ff[k-1][p], s_num_ff[k-1][p][W-1]};
            ge = (t >= {1'b0, s_d_ff[k-1]});
            if (s_div_ff[k-1]) begin
               rem_in[p] = ge ? DW'(t - {1'b0, s_d_ff[k-1]}) : t[DW-1:0];
               num_in[p] = {s_num_ff[k-1][p][W-2:0], 1'b0};
               val_in[p] = {s_val_ff[k-1][p][MW-2:0], ge};
            end else begin
               rem_in[p] = s_rem_ff[k-1][p];
               num_in[p] = s_num_ff[k-1][p];
               val_in[p] = s_val_ff[k-1][p];
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            s_v_ff[k] <= 1'b0;
         end else if (en) begin
            s_v_ff[k] <= s_v_ff[k-1];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            s_div_ff[k] <= s_div_ff[k-1];
            s_dz_ff[k]  <= s_dz_ff[k-1];
            s_neg_ff[k] <= s_neg_ff[k-1];
            s_ovf_ff[k] <= s_ovf_ff[k-1];
            s_val_ff[k] <= val_in;
            s_rem_ff[k] <= rem_in;
            s_num_ff[k] <= num_in;
            s_d_ff[k]   <= s_d_ff[k-1];
         end
      end
   end

   // ------------------------------------------------------------------
   // Output register: saturation and status
   // ------------------------------------------------------------------
   logic             rsp_v_ff;
   cau_pkg::rsp_type rsp_ff, rsp_in;

   always_comb begin
      logic [1:0][W-1:0] res;
      logic [1:0]        sat;
      logic [MW-1:0]     v;
      logic              ng;
      for (int p = 0; p < 2; p++) begin
         v  = s_val_ff[W][p];
         ng = s_neg_ff[W][p];
         sat[p] = s_ovf_ff[W][p] || (ng ? (v > HALF) : (v > MAXP));
         if (sat[p]) begin
            res[p] = ng ? MINV : MAXV;
         end else begin
            res[p] = ng ? W'(-v) : v[W-1:0];
         end
      end
      if (s_dz_ff[W]) begin
         rsp_in.res_real = '0;
         rsp_in.res_imag = '0;
         rsp_in.status   = cau_pkg::ST_DIV0;
      end else begin
         rsp_in.res_real = res[0];
         rsp_in.res_imag = res[1];
         rsp_in.status   = (sat != 2'b00) ? cau_pkg::ST_SAT : cau_pkg::ST_OK;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_v_ff <= 1'b0;
      end else if (en) begin
         rsp_v_ff <= s_v_ff[W];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_v_ff;
   assign rsp_data  = rsp_ff;

   // ------------------------------------------------------------------
   // Assertions
   // ------------------------------------------------------------------
   a_div0_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.status == cau_pkg::ST_DIV0) |->
         (rsp_data.res_real == '0 && rsp_data.res_imag == '0))
      else $error("divide by zero item with nonzero parts");

   a_rem_bound: assert property (@(posedge clock) disable iff (reset)
      (s_v_ff[W] && s_div_ff[W] && !s_dz_ff[W] && s_ovf_ff[W] == 2'b00) |->
         (s_rem_ff[W][0] < s_d_ff[W] && s_rem_ff[W][1] < s_d_ff[W]))
      else $error("divider remainder not below divisor");

   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> !req_stall)
      else $error("request stalled with empty output register");

endmodule

[tb/complex_arithmetic_unit_tb.sv]
// ----------------------------------------------------------------------------
// complex_arithmetic_unit_tb: self-checking bench for the complex arithmetic unit
// Directed operand corners then random items through a bursty sender and a
// stalling receiver; every response is checked against a fixed-point predictor.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module complex_arithmetic_unit_tb;

   localparam int FRAC = cau_pkg::FRAC_BITS_DEF;
   localparam int DW = cau_pkg::DATA_W;
   localparam int LATENCY = cau_pkg::DATA_W + 4;
   localparam int N_RANDOM = 800;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_stall;
   cau_pkg::req_type req_data = '0;
   logic             rsp_valid;
   logic             rsp_stall = 1'b0;
   cau_pkg::rsp_type rsp_data;

   cau_pkg::req_type pending_items[$];
   cau_pkg::rsp_type expected_results[$];
   int      n_mismatch = 0;
   int      n_checked = 0;
   int      n_sent = 0;
   int      n_sat = 0;
   int      n_div0 = 0;
   bit      stim_done = 1'b0;

   complex_arithmetic_unit i_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Clamp a wide value to the field width, flagging saturation
   function automatic logic signed [DW-1:0] clamp_part(input longint v, inout bit sat);
      longint hi, lo;
      hi = (longint'(1) <<< (DW - 1)) - 1;
      lo = -(longint'(1) <<< (DW - 1));
      if (v > hi) begin
         sat = 1'b1;
         return hi[DW-1:0];
      end
      if (v < lo) begin
         sat = 1'b1;
         return lo[DW-1:0];
      end
      return v[DW-1:0];
   endfunction

   // Fixed-point complex result for one operand pair
   function automatic cau_pkg::rsp_type complex_result(input cau_pkg::req_type it);
      longint ar, ai, br, bi, re, im, d;
      bit sat;
      cau_pkg::rsp_type r;
      ar = it.a_real; ai = it.a_imag; br = it.b_real; bi = it.b_imag;
      sat = 1'b0;
      case (it.op)
         cau_pkg::OP_ADD: begin re = ar + br; im = ai + bi; end
         cau_pkg::OP_SUB: begin re = ar - br; im = ai - bi; end
         // arithmetic shift: rounds toward minus infinity
         cau_pkg::OP_MUL: begin
            re = (ar*br - ai*bi) >>> FRAC;
            im = (ar*bi + ai*br) >>> FRAC;
         end
         default: begin
            d = br*br + bi*bi;
            if (d == 0) begin
               r.res_real = '0; r.res_imag = '0; r.status = cau_pkg::ST_DIV0;
               return r;
            end
            // numerators fit well inside 64 bits after the shift; / truncates
            re = ((ar*br + ai*bi) <<< FRAC) / d;
            im = ((ai*br - ar*bi) <<< FRAC) / d;
         end
      endcase
      r.res_real = clamp_part(re, sat);
      r.res_imag = clamp_part(im, sat);
      r.status = sat ? cau_pkg::ST_SAT : cau_pkg::ST_OK;
      return r;
   endfunction

   function automatic cau_pkg::req_type make_item(input cau_pkg::op_type op, input int ar,
                                                  input int ai, input int br, input int bi);
      cau_pkg::req_type it;
      it.op = op;
      it.a_real = ar[DW-1:0]; it.a_imag = ai[DW-1:0];
      it.b_real = br[DW-1:0]; it.b_imag = bi[DW-1:0];
      return it;
   endfunction

   // Random operand part: mostly moderate values, some full range and corners
   function automatic int rand_part();
      case ($urandom_range(0, 9))
         0: return $urandom_range(0, 1) ? 32767 : -32768;
         1, 2, 3: return int'($urandom_range(0, 1023)) - 512;
         4, 5: return int'($urandom_range(0, 8191)) - 4096;
         6: return 0;
         default: return int'($urandom_range(0, 65535)) - 32768;
      endcase
   endfunction

   // Stimulus
   initial begin
      int cv[4];
      cv = '{32767, -32768, 0, -1};
      foreach (cv[k])
         for (int o = 0; o < 4; o++)
            pending_items.push_back(make_item(cau_pkg::op_type'(o), cv[k], cv[(k+1)%4],
                                              cv[(k+2)%4], cv[(k+3)%4]));
      pending_items.push_back(make_item(cau_pkg::OP_DIV, 256, 256, 0, 0));
      pending_items.push_back(make_item(cau_pkg::OP_DIV, -32768, 32767, 1, 0));
      pending_items.push_back(make_item(cau_pkg::OP_DIV, 300, -300, 256, 256));
      pending_items.push_back(make_item(cau_pkg::OP_MUL, -1, -1, 1, 1));
      pending_items.push_back(make_item(cau_pkg::OP_MUL, 32767, 32767, 32767, -32768));
      pending_items.push_back(make_item(cau_pkg::OP_DIV, -1, 0, -32768, -32768));
      for (int n = 0; n < N_RANDOM; n++) begin
         if ($urandom_range(0, 7) == 0)
            pending_items.push_back(make_item(cau_pkg::OP_DIV, rand_part(), rand_part(),
                                              0, 0));
         else
            pending_items.push_back(make_item(cau_pkg::op_type'($urandom_range(0, 3)),
                                              rand_part(), rand_part(), rand_part(),
                                              rand_part()));
      end
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      wait (pending_items.size() == 0 && !req_valid);
      wait (expected_results.size() == 0);
      repeat (LATENCY + 5) @(posedge clock);
      stim_done = 1'b1;
      $display("Checked %0d responses over %0d items, %0d saturated, %0d divide by zero",
               n_checked, n_sent, n_sat, n_div0);
      if (n_mismatch == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

   // Driver: bursts of random length separated by random gaps
   int burst_left = 0;
   int gap_left = 0;
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) begin
            expected_results.push_back(complex_result(req_data));
            n_sent++;
         end
         if (!req_valid || !req_stall) begin
            if (gap_left > 0) begin
               gap_left <= gap_left - 1;
               req_valid <= 1'b0;
            end else if (pending_items.size() > 0) begin
               req_valid <= 1'b1;
               req_data <= pending_items.pop_front();
               if (burst_left <= 1) begin
                  burst_left <= $urandom_range(1, 40);
                  gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
               end else
                  burst_left <= burst_left - 1;
            end else
               req_valid <= 1'b0;
         end
      end
   end

   // Receiver stall pattern: phases of no stall, light stall and heavy stall
   int stall_phase = 0;
   always @(posedge clock) begin
      if ($urandom_range(0, 63) == 0)
         stall_phase <= $urandom_range(0, 2);
      case (stall_phase)
         0: rsp_stall <= 1'b0;
         1: rsp_stall <= ($urandom_range(0, 3) == 0);
         default: rsp_stall <= ($urandom_range(0, 3) != 0);
      endcase
   end

   // Monitor: compare each response with the oldest expectation
   always @(posedge clock) begin
      cau_pkg::rsp_type exp_r;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_results.size() == 0) begin
            n_mismatch++;
            if (n_mismatch <= 10)
               $display("Unexpected response %h", rsp_data);
         end else begin
            exp_r = expected_results.pop_front();
            n_checked++;
            if (exp_r.status == cau_pkg::ST_SAT) n_sat++;
            if (exp_r.status == cau_pkg::ST_DIV0) n_div0++;
            if (rsp_data.res_real !== exp_r.res_real || rsp_data.res_imag !== exp_r.res_imag
                || rsp_data.status !== exp_r.status) begin
               n_mismatch++;
               if (n_mismatch <= 10)
                  $display("Mismatch: expected re %0d im %0d st %s, got re %0d im %0d st %0d",
                           exp_r.res_real, exp_r.res_imag, exp_r.status.name(),
                           rsp_data.res_real, rsp_data.res_imag, rsp_data.status);
            end
         end
      end
   end

   // Watchdog
   initial begin
      #2_000_000;
      if (!stim_done) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

endmodule
